>>> src/lfas_pkg.sv
// Shared types and constants of the LED fill animation shifter.
package lfas_pkg;

   localparam int CHAIN_BITS = 56;
   localparam int CNT_BITS   = $clog2(CHAIN_BITS);
   localparam int SPEED_BITS = 32;
   localparam int TIME_BITS  = 32;
   localparam int CSR_BITS   = 56;
   localparam int DIR_BITS   = 2;
   localparam int IDX_BITS   = 2;

   // Direction codes. Code three takes a time step but sends no frame.
   localparam logic [DIR_BITS-1:0] ANIM_STOP = 2'd0;
   localparam logic [DIR_BITS-1:0] ANIM_UP   = 2'd1;
   localparam logic [DIR_BITS-1:0] ANIM_DOWN = 2'd2;
   localparam logic [DIR_BITS-1:0] ANIM_HOLD = 2'd3;

   // Register indexes.
   localparam logic [IDX_BITS-1:0] CSR_SPEED      = 2'd0;
   localparam logic [IDX_BITS-1:0] CSR_UP_START   = 2'd1;
   localparam logic [IDX_BITS-1:0] CSR_DOWN_START = 2'd2;
   localparam logic [IDX_BITS-1:0] CSR_FULL_MASK  = 2'd3;

   localparam logic [SPEED_BITS-1:0] SPEED_RESET      = 32'd100;
   localparam logic [CHAIN_BITS-1:0] UP_START_RESET   = {1'b1, {(CHAIN_BITS-1){1'b0}}};
   localparam logic [CHAIN_BITS-1:0] DOWN_START_RESET = {{(CHAIN_BITS-1){1'b0}}, 1'b1};
   localparam logic [CHAIN_BITS-1:0] FULL_MASK_RESET  = {CHAIN_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0]   LAST_BIT_CNT     = CNT_BITS'(CHAIN_BITS - 1);

   typedef struct packed {
      logic [SPEED_BITS-1:0] speed_ms;
      logic [CHAIN_BITS-1:0] up_start;
      logic [CHAIN_BITS-1:0] down_start;
      logic [CHAIN_BITS-1:0] full_mask;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [CHAIN_BITS-1:0] data;
   } frame_type;

endpackage

>>> src/lfas_csr.sv
// Configuration registers of the LED fill animation shifter.
module lfas_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [lfas_pkg::IDX_BITS-1:0] csr_index,
   input  logic [lfas_pkg::CSR_BITS-1:0] csr_wdata,
   output lfas_pkg::cfg_type             cfg
);
   import lfas_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SPEED:      cfg_in.speed_ms   = csr_wdata[SPEED_BITS-1:0];
            CSR_UP_START:   cfg_in.up_start   = csr_wdata[CHAIN_BITS-1:0];
            CSR_DOWN_START: cfg_in.down_start = csr_wdata[CHAIN_BITS-1:0];
            CSR_FULL_MASK:  cfg_in.full_mask  = csr_wdata[CHAIN_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_ms   <= SPEED_RESET;
         cfg_ff.up_start   <= UP_START_RESET;
         cfg_ff.down_start <= DOWN_START_RESET;
         cfg_ff.full_mask  <= FULL_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/lfas_step.sv
// Request register, time gate, fill pattern update and frame buffer.
module lfas_step (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lfas_pkg::DIR_BITS-1:0]   req_direction,
   input  logic [lfas_pkg::TIME_BITS-1:0]  req_now_ms,
   input  lfas_pkg::cfg_type               cfg,
   input  logic                            frame_taken,
   output lfas_pkg::frame_type             frame
);
   import lfas_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic [DIR_BITS-1:0]   s1_dir_ff, s1_dir_in;
   logic [TIME_BITS-1:0]  s1_now_ff, s1_now_in;
   logic [CHAIN_BITS-1:0] up_ff, up_in;
   logic [CHAIN_BITS-1:0] down_ff, down_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   frame_type             fbuf_ff, fbuf_in;

   logic                  req_accept;
   logic                  gate_pass;
   logic                  emits;
   logic                  advance;
   logic [TIME_BITS-1:0]  elapsed;
   logic [CHAIN_BITS-1:0] up_grown;
   logic [CHAIN_BITS-1:0] down_grown;
   logic [CHAIN_BITS-1:0] frame_data;

   assign elapsed   = s1_now_ff - last_ff;
   assign gate_pass = (elapsed >= cfg.speed_ms);
   assign emits     = (s1_dir_ff == ANIM_STOP) ||
                      (gate_pass && (s1_dir_ff == ANIM_UP || s1_dir_ff == ANIM_DOWN));

   // A request that sends a frame waits until the buffer is free or being emptied.
   assign advance    = s1_valid_ff && (!emits || !fbuf_ff.valid || frame_taken);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign up_grown   = up_ff | (up_ff >> 1);
   assign down_grown = down_ff | (down_ff << 1);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_dir_in   = s1_dir_ff;
      s1_now_in   = s1_now_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_dir_in   = req_direction;
         s1_now_in   = req_now_ms;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      up_in      = up_ff;
      down_in    = down_ff;
      last_in    = last_ff;
      frame_data = '0;
      if (advance) begin
         if (s1_dir_ff == ANIM_STOP) begin
            up_in   = cfg.up_start;
            down_in = cfg.down_start;
         end else if (gate_pass) begin
            last_in = s1_now_ff;
            case (s1_dir_ff)
               ANIM_UP: begin
                  frame_data = up_ff;
                  up_in      = (up_grown == cfg.full_mask) ? cfg.up_start : up_grown;
               end
               ANIM_DOWN: begin
                  frame_data = down_ff;
                  down_in    = (down_grown == cfg.full_mask) ? cfg.down_start : down_grown;
               end
               default: frame_data = '0;
            endcase
         end
      end
   end

   always_comb begin
      fbuf_in = fbuf_ff;
      if (frame_taken) begin
         fbuf_in.valid = 1'b0;
      end
      if (advance && emits) begin
         fbuf_in.valid = 1'b1;
         fbuf_in.data  = frame_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         up_ff         <= UP_START_RESET;
         down_ff       <= DOWN_START_RESET;
         last_ff       <= '0;
         fbuf_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         up_ff         <= up_in;
         down_ff       <= down_in;
         last_ff       <= last_in;
         fbuf_ff.valid <= fbuf_in.valid;
      end
      s1_dir_ff    <= s1_dir_in;
      s1_now_ff    <= s1_now_in;
      fbuf_ff.data <= fbuf_in.data;
   end

   assign frame = fbuf_ff;

   // A waiting frame is never overwritten before the serializer takes it.
   a_fbuf_held: assert property (@(posedge clock) disable iff (reset)
      fbuf_ff.valid && !frame_taken |=> fbuf_ff.valid && $stable(fbuf_ff.data))
      else $error("frame buffer overwritten");

   // A stop request reloads both patterns from the start registers.
   a_stop_reload: assert property (@(posedge clock) disable iff (reset)
      advance && s1_dir_ff == ANIM_STOP |=>
      up_ff == $past(cfg.up_start) && down_ff == $past(cfg.down_start))
      else $error("stop did not reload patterns");

endmodule

>>> src/lfas_ser.sv
// Frame serializer: shifts a buffered frame out one bit per response.
module lfas_ser (
   input  logic                clock,
   input  logic                reset,
   input  lfas_pkg::frame_type frame,
   output logic                frame_taken,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_serial_bit,
   output logic                rsp_latch_after
);
   import lfas_pkg::*;

   logic                  active_ff, active_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [CHAIN_BITS-1:0] shift_ff, shift_in;
   logic                  rsp_accept;
   logic                  last_bit;

   assign rsp_accept  = active_ff && !rsp_stall;
   assign last_bit    = (cnt_ff == '0);
   assign frame_taken = frame.valid && (!active_ff || (rsp_accept && last_bit));

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      if (frame_taken) begin
         active_in = 1'b1;
         cnt_in    = LAST_BIT_CNT;
         shift_in  = frame.data;
      end else if (rsp_accept) begin
         if (last_bit) begin
            active_in = 1'b0;
         end else begin
            cnt_in   = cnt_ff - 1'b1;
            shift_in = shift_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      shift_ff <= shift_in;
   end

   assign rsp_valid       = active_ff;
   assign rsp_serial_bit  = shift_ff[CHAIN_BITS-1];
   assign rsp_latch_after = last_bit;

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      frame_taken |=> active_ff && cnt_ff == LAST_BIT_CNT)
      else $error("frame loaded with wrong bit count");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !last_bit |=> active_ff && cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("bit count did not step");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && last_bit && !frame.valid |=> !active_ff)
      else $error("serializer ran past the last bit");

endmodule

>>> src/led_fill_animation_shifter.sv
// Top level of the LED fill animation shifter.
// An accepted request is held in the request register and its frame in the frame buffer;
// the serializer then loads it and shifts one bit per cycle while rsp_stall is low.
// A request that sends no frame never waits on the frame buffer.
// One frame waits in a buffer while another shifts; frame requests stall only when both are busy.
// Reset: registers return to their defaults, patterns to the start defaults, time to zero.
module led_fill_animation_shifter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lfas_pkg::DIR_BITS-1:0]  req_direction,
   input  logic [lfas_pkg::TIME_BITS-1:0] req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_serial_bit,
   output logic                           rsp_latch_after,
   input  logic                           csr_write,
   input  logic [lfas_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [lfas_pkg::CSR_BITS-1:0]  csr_wdata
);
   import lfas_pkg::*;

   cfg_type   cfg;
   frame_type frame;
   logic      frame_taken;

   lfas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfas_step u_step (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_direction (req_direction),
      .req_now_ms    (req_now_ms),
      .cfg           (cfg),
      .frame_taken   (frame_taken),
      .frame         (frame)
   );

   lfas_ser u_ser (
      .clock           (clock),
      .reset           (reset),
      .frame           (frame),
      .frame_taken     (frame_taken),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_after (rsp_latch_after)
   );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LED fill animation shifter: predicts every frame bit and compares.
module tb;
   import lfas_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_CHUNKS = 5;
   localparam int CHUNK_ITEMS   = 50;

   typedef struct packed {
      logic [DIR_BITS-1:0]  direction;
      logic [TIME_BITS-1:0] now_ms;
   } request_type;

   typedef struct packed {
      logic serial_bit;
      logic latch_after;
   } frame_bit_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DIR_BITS-1:0]   req_direction = '0;
   logic [TIME_BITS-1:0]  req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_serial_bit;
   logic                  rsp_latch_after;
   logic                  csr_write = 1'b0;
   logic [IDX_BITS-1:0]   csr_index = '0;
   logic [CSR_BITS-1:0]   csr_wdata = '0;

   request_type   pending_requests[$];
   frame_bit_type expected_bits[$];
   int            errors = 0;
   int            cycles = 0;
   int            req_gap = 0;
   int            stall_left = 0;
   bit            calm = 1'b0;

   // Animation state and register copies used for prediction.
   logic [SPEED_BITS-1:0] speed_ms     = SPEED_RESET;
   logic [CHAIN_BITS-1:0] up_start     = UP_START_RESET;
   logic [CHAIN_BITS-1:0] down_start   = DOWN_START_RESET;
   logic [CHAIN_BITS-1:0] full_mask    = FULL_MASK_RESET;
   logic [CHAIN_BITS-1:0] up_pattern   = UP_START_RESET;
   logic [CHAIN_BITS-1:0] down_pattern = DOWN_START_RESET;
   logic [TIME_BITS-1:0]  last_step_ms = '0;

   led_fill_animation_shifter uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_direction   (req_direction),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_after (rsp_latch_after),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short idles, a few long ones, none at all while calm.
   function automatic int idle_length(input int longest);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, longest);
   endfunction

   function automatic logic [CHAIN_BITS-1:0] fill_pattern(input logic [CHAIN_BITS-1:0] start,
                                                         input int steps, input bit toward_lsb);
      logic [CHAIN_BITS-1:0] p;
      p = start;
      for (int i = 0; i < steps; i++) p = toward_lsb ? (p | (p >> 1)) : (p | (p << 1));
      return p;
   endfunction

   task automatic queue_frame(input logic [CHAIN_BITS-1:0] frame);
      for (int k = CHAIN_BITS - 1; k >= 0; k--) expected_bits.push_back('{frame[k], k == 0});
   endtask

   task automatic advance_animation(input request_type req);
      logic [TIME_BITS-1:0]  elapsed;
      logic [CHAIN_BITS-1:0] frame;
      elapsed = req.now_ms - last_step_ms;
      if (req.direction == ANIM_STOP) begin
         // A stop bypasses the time gate and keeps the last step time.
         up_pattern   = up_start;
         down_pattern = down_start;
         queue_frame('0);
      end else if (elapsed >= speed_ms) begin
         last_step_ms = req.now_ms;
         if (req.direction == ANIM_UP) begin
            frame      = up_pattern;
            up_pattern = fill_pattern(up_pattern, 1, 1'b1);
            if (up_pattern == full_mask) up_pattern = up_start;
            queue_frame(frame);
         end else if (req.direction == ANIM_DOWN) begin
            frame        = down_pattern;
            down_pattern = fill_pattern(down_pattern, 1, 1'b0);
            if (down_pattern == full_mask) down_pattern = down_start;
            queue_frame(frame);
         end
      end
   endtask

   task automatic add_request(input logic [DIR_BITS-1:0] dir, input logic [TIME_BITS-1:0] now);
      pending_requests.push_back('{dir, now});
   endtask

   task automatic write_csr(input logic [IDX_BITS-1:0] idx, input logic [CSR_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SPEED:      speed_ms   = data[SPEED_BITS-1:0];
         CSR_UP_START:   up_start   = data[CHAIN_BITS-1:0];
         CSR_DOWN_START: down_start = data[CHAIN_BITS-1:0];
         CSR_FULL_MASK:  full_mask  = data[CHAIN_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Sampling on the falling edge keeps this free of races with the clocked blocks.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_bits.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_start(input logic [IDX_BITS-1:0] idx);
      logic [CSR_BITS-1:0] word;
      word = CSR_BITS'({$urandom(), $urandom()});
      case ($urandom_range(0, 4))
         0: word = CSR_BITS'(1) << $urandom_range(0, CHAIN_BITS - 1);
         1: word = '0;
         2: word = (idx == CSR_UP_START) ? UP_START_RESET : DOWN_START_RESET;
         default: ;
      endcase
      write_csr(idx, word);
   endtask

   task automatic randomize_config();
      logic [CSR_BITS-1:0] word;
      word = CSR_BITS'({$urandom(), $urandom()});
      case ($urandom_range(0, 9))
         0: word[SPEED_BITS-1:0] = '0;
         1: word[SPEED_BITS-1:0] = '1;
         2: ;
         default: word[SPEED_BITS-1:0] = $urandom_range(1, 200);
      endcase
      write_csr(CSR_SPEED, word);
      random_start(CSR_UP_START);
      random_start(CSR_DOWN_START);
      word = CSR_BITS'({$urandom(), $urandom()});
      case ($urandom_range(0, 4))
         0: word = FULL_MASK_RESET;
         1: word = fill_pattern(up_start, $urandom_range(1, 8), 1'b1);
         2: word = fill_pattern(down_start, $urandom_range(1, 8), 1'b0);
         3: word = '0;
         default: ;
      endcase
      write_csr(CSR_FULL_MASK, word);
   endtask

   always @(posedge clock) begin : driver
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) advance_animation('{req_direction, req_now_ms});
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            req_valid     <= 1'b1;
            req_direction <= next_req.direction;
            req_now_ms    <= next_req.now_ms;
            req_gap = idle_length(40);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      frame_bit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bits.size() == 0) begin
            $display("%0t: unexpected frame bit, got serial_bit=%0b latch_after=%0b",
                     $time, rsp_serial_bit, rsp_latch_after);
            errors++;
         end else begin
            want = expected_bits.pop_front();
            if (rsp_serial_bit !== want.serial_bit) begin
               $display("%0t: serial_bit expected %0b, got %0b",
                        $time, want.serial_bit, rsp_serial_bit);
               errors++;
            end
            if (rsp_latch_after !== want.latch_after) begin
               $display("%0t: latch_after expected %0b, got %0b",
                        $time, want.latch_after, rsp_latch_after);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_length(30);
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [TIME_BITS-1:0] t;
      logic [DIR_BITS-1:0]  run_dir;
      int                   r;
      run_dir = ANIM_UP;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default registers: gate edges, code three, stop without gate, time wrap.
      add_request(ANIM_STOP, 32'd0);
      add_request(ANIM_UP, 32'd100);
      add_request(ANIM_UP, 32'd199);
      add_request(ANIM_DOWN, 32'd200);
      add_request(ANIM_DOWN, 32'd299);
      add_request(ANIM_HOLD, 32'd300);
      add_request(ANIM_UP, 32'd399);
      add_request(ANIM_UP, 32'd400);
      add_request(ANIM_STOP, 32'hFFFF_FFFF);
      add_request(ANIM_DOWN, 32'hFFFF_FFF0);
      add_request(ANIM_DOWN, 32'h0000_0053);
      add_request(ANIM_DOWN, 32'h0000_0054);
      wait_idle();

      // Zero speed with upper write bits set, a small reachable mask, an all-zero up start.
      write_csr(CSR_SPEED, {{(CSR_BITS - SPEED_BITS){1'b1}}, {SPEED_BITS{1'b0}}});
      write_csr(CSR_UP_START, '0);
      write_csr(CSR_DOWN_START, CSR_BITS'(1));
      write_csr(CSR_FULL_MASK, CSR_BITS'(7));
      t = last_step_ms;
      add_request(ANIM_STOP, t);
      repeat (4) add_request(ANIM_DOWN, t);
      repeat (2) add_request(ANIM_UP, t);
      add_request(ANIM_HOLD, t);
      wait_idle();

      // Largest speed, saturating patterns, a mask that is never reached.
      // The down pattern keeps running until the stop picks up the new start.
      write_csr(CSR_SPEED, '1);
      write_csr(CSR_UP_START, '1);
      write_csr(CSR_DOWN_START, CSR_BITS'(UP_START_RESET));
      write_csr(CSR_FULL_MASK, '0);
      t = last_step_ms;
      add_request(ANIM_DOWN, t - 32'd1);
      add_request(ANIM_UP, t - 32'd1);
      add_request(ANIM_STOP, t + 32'd5);
      add_request(ANIM_UP, t - 32'd2);
      add_request(ANIM_DOWN, t - 32'd3);
      add_request(ANIM_DOWN, t - 32'd4);

      for (int c = 0; c < RANDOM_CHUNKS; c++) begin
         wait_idle();
         randomize_config();
         calm = ($urandom_range(0, 3) == 0);
         t = last_step_ms;
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) run_dir = $urandom_range(0, 1) ? ANIM_UP : ANIM_DOWN;
            if (r < 70) begin
               // Steps spaced just at or past the speed, so the fill keeps moving.
               t = t + speed_ms + $urandom_range(0, 3);
               add_request(run_dir, t);
            end else if (r < 82) begin
               add_request(ANIM_STOP, $urandom());
            end else begin
               add_request(DIR_BITS'($urandom_range(1, 3)),
                           t + (speed_ms >> $urandom_range(0, 2)));
            end
         end
      end
      calm = 1'b0;

      wait_idle();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
